// File: rtl/core/usrm_pkg.sv
// Package for the USART register model: field types, bit positions, register
// offsets, item kinds and the character-size mask function.
// No dependencies; every other file of the block imports it.
`default_nettype none

package usrm_pkg;

   // Payload field types
   typedef logic [1:0] kind_type;
   typedef logic [2:0] addr_type;
   typedef logic [7:0] byte_type;
   typedef logic [3:0] nibble_type;

   // Item kinds
   localparam kind_type KIND_READ  = 2'd0;
   localparam kind_type KIND_WRITE = 2'd1;
   localparam kind_type KIND_LINE  = 2'd2;
   localparam kind_type KIND_POWER = 2'd3;

   // Register offsets
   localparam addr_type ADDR_STATUS_A  = 3'd0;
   localparam addr_type ADDR_CONTROL_B = 3'd1;
   localparam addr_type ADDR_CONTROL_C = 3'd2;
   localparam addr_type ADDR_BAUD_LOW  = 3'd4;
   localparam addr_type ADDR_BAUD_HIGH = 3'd5;
   localparam addr_type ADDR_DATA      = 3'd6;

   // Status A bits
   localparam int SA_DRE = 5;
   localparam int SA_TXC = 6;
   localparam int SA_RXC = 7;

   // Control B bits
   localparam int CB_CSZ2  = 2;
   localparam int CB_TXEN  = 3;
   localparam int CB_RXEN  = 4;
   localparam int CB_DREIE = 5;
   localparam int CB_TXCIE = 6;
   localparam int CB_RXCIE = 7;

   // Control C bits
   localparam int CC_CSZ0 = 1;
   localparam int CC_CSZ1 = 2;

   // Write masks and reset values
   localparam byte_type   SA_WRITABLE    = 8'b0100_0011;
   localparam byte_type   CB_WRITABLE    = 8'b1111_1101;
   localparam byte_type   SA_RESET       = 8'b0010_0000;
   localparam byte_type   CB_RESET       = 8'h00;
   localparam byte_type   CC_RESET       = 8'b0000_0110;
   localparam nibble_type BAUD_HIGH_MASK = 4'b1111;

   // Character masks
   localparam byte_type MASK_5 = 8'b0001_1111;
   localparam byte_type MASK_6 = 8'b0011_1111;
   localparam byte_type MASK_7 = 8'b0111_1111;
   localparam byte_type MASK_8 = 8'hFF;

   // One input item
   typedef struct packed {
      kind_type kind;
      addr_type addr;
      byte_type wr_data;
      byte_type rx_byte;
      logic     level;
   } req_type;

   // One result item
   typedef struct packed {
      byte_type read_data;
      logic     tx_valid;
      byte_type tx_byte;
      logic     rxc_irq;
      logic     txc_irq;
      logic     dre_irq;
      logic     rx_ready;
      logic     rx_dropped;
   } rsp_type;

   // Mask for the size mode CSZ2:CSZ1:CSZ0; reserved modes keep the old mask
   function automatic byte_type size_mask(input byte_type cb, input byte_type cc,
                                          input byte_type prev);
      logic [2:0] mode;
      byte_type   mask;
      mode = {cb[CB_CSZ2], cc[CC_CSZ1], cc[CC_CSZ0]};
      unique case (mode)
         3'd0:    mask = MASK_5;
         3'd1:    mask = MASK_6;
         3'd2:    mask = MASK_7;
         3'd3:    mask = MASK_8;
         3'd7:    mask = MASK_8;
         default: mask = prev;
      endcase
      return mask;
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/usrm_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on usrm_pkg for the field types.
`default_nettype none

interface usrm_req_if;
   import usrm_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   addr_type addr;
   byte_type wr_data;
   byte_type rx_byte;
   logic     level;

   modport source (output valid, kind, addr, wr_data, rx_byte, level, input ready);
   modport sink   (input valid, kind, addr, wr_data, rx_byte, level, output ready);
endinterface

interface usrm_rsp_if;
   import usrm_pkg::*;

   logic     valid;
   logic     ready;
   byte_type read_data;
   logic     tx_valid;
   byte_type tx_byte;
   logic     rxc_irq;
   logic     txc_irq;
   logic     dre_irq;
   logic     rx_ready;
   logic     rx_dropped;

   modport source (output valid, read_data, tx_valid, tx_byte, rxc_irq, txc_irq,
                   dre_irq, rx_ready, rx_dropped, input ready);
   modport sink   (input valid, read_data, tx_valid, tx_byte, rxc_irq, txc_irq,
                   dre_irq, rx_ready, rx_dropped, output ready);
endinterface

`default_nettype wire

// File: rtl/core/usrm_in_stage.sv
// Input register of the USART register model: captures one request transfer
// and holds it until the register file consumes it. Depends on usrm_pkg, usrm_if.
`default_nettype none

module usrm_in_stage (
   input  wire logic            clock,
   input  wire logic            reset,
   usrm_req_if.sink             req_if,
   input  wire logic            advance,
   output usrm_pkg::req_type    item,
   output logic                 item_valid
);
   import usrm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;
   logic    take;

   // Accept while empty or while the held item moves on
   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload of the last transfer
   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{kind: req_if.kind, addr: req_if.addr, wr_data: req_if.wr_data,
                      rx_byte: req_if.rx_byte, level: req_if.level};
      end
   end

   assign item       = item_ff;
   assign item_valid = valid_ff;

endmodule

`default_nettype wire

// File: rtl/core/usrm_regfile.sv
// Register state of the USART model and the single-pass update logic that
// turns one item into the next state and its result. Depends on usrm_pkg.
`default_nettype none

module usrm_regfile (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire usrm_pkg::req_type item,
   input  wire logic            advance,
   output usrm_pkg::rsp_type    result
);
   import usrm_pkg::*;

   byte_type   status_a_ff,  status_a_in;
   byte_type   control_b_ff, control_b_in;
   byte_type   control_c_ff, control_c_in;
   byte_type   baud_low_ff,  baud_low_in;
   nibble_type baud_high_ff, baud_high_in;
   byte_type   rx_holder_ff, rx_holder_in;
   logic       rx_full_ff,   rx_full_in;
   byte_type   char_mask_ff, char_mask_in;
   logic       enabled_ff,   enabled_in;
   logic       rxc_irq_ff,   rxc_irq_in;
   logic       txc_irq_ff,   txc_irq_in;
   logic       dre_irq_ff,   dre_irq_in;

   byte_type   sa_wr;
   byte_type   cb_wr;
   byte_type   read_data;
   logic       tx_valid;
   byte_type   tx_byte;
   logic       dropped;

   // Merged values for status A and control B writes
   assign sa_wr = (item.wr_data & SA_WRITABLE) | (status_a_ff & ~SA_WRITABLE);
   assign cb_wr = (item.wr_data & CB_WRITABLE) | (control_b_ff & ~CB_WRITABLE);

   // Next state and result for the held item
   always_comb begin
      status_a_in  = status_a_ff;
      control_b_in = control_b_ff;
      control_c_in = control_c_ff;
      baud_low_in  = baud_low_ff;
      baud_high_in = baud_high_ff;
      rx_holder_in = rx_holder_ff;
      rx_full_in   = rx_full_ff;
      char_mask_in = char_mask_ff;
      enabled_in   = enabled_ff;
      rxc_irq_in   = rxc_irq_ff;
      txc_irq_in   = txc_irq_ff;
      dre_irq_in   = dre_irq_ff;
      read_data    = '0;
      tx_valid     = 1'b0;
      tx_byte      = '0;
      dropped      = 1'b0;

      unique case (item.kind)
         KIND_READ: begin
            if (enabled_ff) begin
               unique case (item.addr)
                  ADDR_DATA: begin
                     // Drain the holder when the receiver is on
                     if (control_b_ff[CB_RXEN]) begin
                        if (rx_full_ff) begin
                           read_data = rx_holder_ff & char_mask_ff;
                        end
                        rx_full_in          = 1'b0;
                        status_a_in[SA_RXC] = 1'b0;
                        rxc_irq_in          = 1'b0;
                     end
                  end
                  ADDR_STATUS_A:  read_data = status_a_ff;
                  ADDR_CONTROL_B: read_data = control_b_ff;
                  ADDR_CONTROL_C: read_data = control_c_ff;
                  ADDR_BAUD_LOW:  read_data = baud_low_ff;
                  ADDR_BAUD_HIGH: read_data = {4'b0000, baud_high_ff};
                  default:        read_data = '0;
               endcase
            end
         end
         KIND_WRITE: begin
            if (enabled_ff) begin
               unique case (item.addr)
                  ADDR_DATA: begin
                     // Send the byte when the transmitter is on
                     if (control_b_ff[CB_TXEN]) begin
                        status_a_in         = status_a_ff;
                        status_a_in[SA_TXC] = 1'b1;
                        status_a_in[SA_DRE] = 1'b1;
                        if (control_b_ff[CB_TXCIE]) begin
                           txc_irq_in          = 1'b1;
                           status_a_in[SA_TXC] = 1'b0;
                        end
                        if (control_b_ff[CB_DREIE]) begin
                           dre_irq_in = 1'b1;
                        end
                        tx_valid = 1'b1;
                        tx_byte  = item.wr_data;
                     end
                  end
                  ADDR_STATUS_A: begin
                     // Writing a one to TXC clears it and its interrupt
                     status_a_in = sa_wr;
                     if (sa_wr[SA_TXC]) begin
                        status_a_in[SA_TXC] = 1'b0;
                        txc_irq_in          = 1'b0;
                     end
                  end
                  ADDR_CONTROL_B: begin
                     control_b_in = cb_wr;
                     if (!cb_wr[CB_RXEN]) begin
                        rx_full_in = 1'b0;
                     end
                     rxc_irq_in   = cb_wr[CB_RXCIE] & status_a_ff[SA_RXC];
                     txc_irq_in   = cb_wr[CB_TXCIE] & status_a_ff[SA_TXC];
                     dre_irq_in   = cb_wr[CB_DREIE] & status_a_ff[SA_DRE];
                     char_mask_in = size_mask(cb_wr, control_c_ff, char_mask_ff);
                  end
                  ADDR_CONTROL_C: begin
                     control_c_in = item.wr_data;
                     char_mask_in = size_mask(control_b_ff, item.wr_data, char_mask_ff);
                  end
                  ADDR_BAUD_LOW:  baud_low_in  = item.wr_data;
                  ADDR_BAUD_HIGH: baud_high_in = item.wr_data[3:0] & BAUD_HIGH_MASK;
                  default: begin
                  end
               endcase
            end
         end
         KIND_LINE: begin
            // Drop the byte when the receiver is off or the holder is full
            if (rx_full_ff || !control_b_ff[CB_RXEN]) begin
               dropped = 1'b1;
            end else begin
               rx_holder_in        = item.rx_byte;
               rx_full_in          = 1'b1;
               status_a_in[SA_RXC] = 1'b1;
               if (control_b_ff[CB_RXCIE]) begin
                  rxc_irq_in = 1'b1;
               end
            end
         end
         KIND_POWER: begin
            // Power reduction (level high) disables the block and resets the registers; level low re-enables it
            enabled_in = !item.level;
            if (item.level) begin
               status_a_in  = SA_RESET;
               control_b_in = CB_RESET;
               control_c_in = CC_RESET;
               baud_low_in  = '0;
               baud_high_in = '0;
               rx_full_in   = 1'b0;
               char_mask_in = size_mask(CB_RESET, CC_RESET, char_mask_ff);
               rxc_irq_in   = 1'b0;
               txc_irq_in   = 1'b0;
               dre_irq_in   = 1'b0;
            end
         end
      endcase
   end

   assign result = '{read_data: read_data, tx_valid: tx_valid, tx_byte: tx_byte,
                     rxc_irq: rxc_irq_in, txc_irq: txc_irq_in, dre_irq: dre_irq_in,
                     rx_ready: control_b_in[CB_RXEN] & !rx_full_in,
                     rx_dropped: dropped};

   // Control state: advance only when the item moves to the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         status_a_ff  <= SA_RESET;
         control_b_ff <= CB_RESET;
         control_c_ff <= CC_RESET;
         baud_low_ff  <= '0;
         baud_high_ff <= '0;
         rx_full_ff   <= 1'b0;
         char_mask_ff <= MASK_8;
         enabled_ff   <= 1'b1;
         rxc_irq_ff   <= 1'b0;
         txc_irq_ff   <= 1'b0;
         dre_irq_ff   <= 1'b0;
      end else if (advance) begin
         status_a_ff  <= status_a_in;
         control_b_ff <= control_b_in;
         control_c_ff <= control_c_in;
         baud_low_ff  <= baud_low_in;
         baud_high_ff <= baud_high_in;
         rx_full_ff   <= rx_full_in;
         char_mask_ff <= char_mask_in;
         enabled_ff   <= enabled_in;
         rxc_irq_ff   <= rxc_irq_in;
         txc_irq_ff   <= txc_irq_in;
         dre_irq_ff   <= dre_irq_in;
      end
   end

   // Receive holder carries data only
   always_ff @(posedge clock) begin
      if (advance) begin
         rx_holder_ff <= rx_holder_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/usrm_out_stage.sv
// Output register of the USART register model: holds one result until the
// response transfer completes. Depends on usrm_pkg, usrm_if.
`default_nettype none

module usrm_out_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire usrm_pkg::rsp_type result,
   input  wire logic              load,
   output logic                   free,
   usrm_rsp_if.source             rsp_if
);
   import usrm_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // Free when empty or when the held result leaves this cycle
   assign free = !valid_ff || rsp_if.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_if.valid      = valid_ff;
   assign rsp_if.read_data  = data_ff.read_data;
   assign rsp_if.tx_valid   = data_ff.tx_valid;
   assign rsp_if.tx_byte    = data_ff.tx_byte;
   assign rsp_if.rxc_irq    = data_ff.rxc_irq;
   assign rsp_if.txc_irq    = data_ff.txc_irq;
   assign rsp_if.dre_irq    = data_ff.dre_irq;
   assign rsp_if.rx_ready   = data_ff.rx_ready;
   assign rsp_if.rx_dropped = data_ff.rx_dropped;

endmodule

`default_nettype wire

// File: rtl/core/usart_register_model_unit.sv
// USART register model, top level: input register, register file, output register.
// Depends on usrm_pkg, usrm_if, usrm_in_stage, usrm_regfile, usrm_out_stage.
//
// Usage:
//   req_if carries one item per transfer: a bus read, a bus write, a byte
//   arriving from the line, or a power-reduction level. rsp_if returns exactly
//   one result per item, in order: read data, a transmitted byte with its
//   valid flag, the three interrupt levels, receiver readiness and a drop flag.
//   Path: a request is held in the input register, and its result is loaded
//   into the output register, which presents it on rsp_if.
//   Throughput: one item per cycle while rsp_if.ready stays high; the register
//   update is a single pass of logic between the input and output registers.
//   Stall: when rsp_if.ready is low the output register holds its result, the
//   input register holds one more item, and req_if.ready then drops until the
//   output side drains. The register state advances only when an item moves
//   into the output register.
//   Reset (synchronous, active high): both stages empty, registers take their
//   power-on values (status A with data register empty, eight-bit characters).
//   The receive holder is not cleared; it is read only while marked full.
`default_nettype none

module usart_register_model_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   usrm_req_if.sink   req_if,
   usrm_rsp_if.source rsp_if
);
   import usrm_pkg::*;

   req_type item;
   logic    item_valid;
   rsp_type result;
   logic    out_free;
   logic    advance;

   // Move the held item on when the output register can take it
   assign advance = item_valid && out_free;

   usrm_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item       (item),
      .item_valid (item_valid)
   );

   usrm_regfile u_regfile (
      .clock   (clock),
      .reset   (reset),
      .item    (item),
      .advance (advance),
      .result  (result)
   );

   usrm_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .result (result),
      .load   (advance),
      .free   (out_free),
      .rsp_if (rsp_if)
   );

`ifndef SYNTH
   // No result is presented right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_if.valid)
      else $error("response valid in the cycle after reset");

   // A transmitted byte only comes from a data register write
   a_tx_from_data_write: assert property (@(posedge clock) disable iff (reset)
      advance && result.tx_valid |-> item.kind == KIND_WRITE && item.addr == ADDR_DATA)
      else $error("tx result from an item that is not a data write");

   // Power reduction clears every interrupt and the receiver
   a_power_down_clears: assert property (@(posedge clock) disable iff (reset)
      advance && item.kind == KIND_POWER && item.level
      |=> !rsp_if.rxc_irq && !rsp_if.txc_irq && !rsp_if.dre_irq && !rsp_if.rx_ready)
      else $error("power reduction left an interrupt or the receiver active");

   // A loaded result is presented in the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_if.valid)
      else $error("loaded result not presented");
`endif

endmodule

`default_nettype wire

// File: test/usart_register_model_unit_checker.sv
// Checker for the USART register model: watches both channels, tracks the register
// state on every request transfer and compares each response transfer field by field.
// Depends on usrm_pkg and usrm_if.
`timescale 1ns / 100ps

module usart_register_model_unit_checker (
   input  wire logic clock,
   input  wire logic reset,
   usrm_req_if       req_mon,
   usrm_rsp_if       rsp_mon,
   output int        fail_count,
   output int        pending,
   output int        checked,
   output int        tx_sent,
   output int        dropped
);
   import usrm_pkg::*;

   // Shadow copy of the register file
   byte_type   m_status;
   byte_type   m_ctrl_b;
   byte_type   m_ctrl_c;
   byte_type   m_baud_lo;
   nibble_type m_baud_hi;
   byte_type   m_holder;
   byte_type   m_mask;
   logic       m_full;
   logic       m_on;
   logic       m_irq_rxc;
   logic       m_irq_txc;
   logic       m_irq_dre;

   rsp_type predicted_replies[$];

   // Character width from CSZ2:CSZ1:CSZ0; reserved widths leave the mask alone
   function automatic byte_type char_width_mask(byte_type cb, byte_type cc, byte_type prev);
      logic [2:0] mode;
      mode = {cb[CB_CSZ2], cc[CC_CSZ1], cc[CC_CSZ0]};
      if (!mode[2])
         return 8'hFF >> (2'd3 - mode[1:0]);
      else if (mode == 3'b111)
         return MASK_8;
      else
         return prev;
   endfunction

   // Return the registers to their power-on values; the holder keeps its byte
   task automatic clear_regs();
      m_full    = 1'b0;
      m_status  = SA_RESET;
      m_ctrl_b  = CB_RESET;
      m_ctrl_c  = CC_RESET;
      m_baud_lo = '0;
      m_baud_hi = '0;
      m_mask    = char_width_mask(CB_RESET, CC_RESET, m_mask);
      m_irq_rxc = 1'b0;
      m_irq_txc = 1'b0;
      m_irq_dre = 1'b0;
   endtask

   // Advance the shadow registers by one item and work out its response
   task automatic step_usart_regs(input req_type it, output rsp_type res);
      res = '0;
      case (it.kind)
         KIND_READ: begin
            if (m_on) begin
               case (it.addr)
                  ADDR_DATA: begin
                     if (m_ctrl_b[CB_RXEN]) begin
                        if (m_full) begin
                           res.read_data = m_holder & m_mask;
                           m_full = 1'b0;
                        end
                        m_status[SA_RXC] = 1'b0;
                        m_irq_rxc = 1'b0;
                     end
                  end
                  ADDR_STATUS_A:  res.read_data = m_status;
                  ADDR_CONTROL_B: res.read_data = m_ctrl_b;
                  ADDR_CONTROL_C: res.read_data = m_ctrl_c;
                  ADDR_BAUD_LOW:  res.read_data = m_baud_lo;
                  ADDR_BAUD_HIGH: res.read_data = {4'b0000, m_baud_hi};
                  default: ;
               endcase
            end
         end
         KIND_WRITE: begin
            if (m_on) begin
               case (it.addr)
                  ADDR_DATA: begin
                     if (m_ctrl_b[CB_TXEN]) begin
                        m_status[SA_TXC] = 1'b1;
                        m_status[SA_DRE] = 1'b1;
                        // TXC is handed straight to the interrupt when enabled
                        if (m_ctrl_b[CB_TXCIE]) begin
                           m_irq_txc = 1'b1;
                           m_status[SA_TXC] = 1'b0;
                        end
                        if (m_ctrl_b[CB_DREIE])
                           m_irq_dre = 1'b1;
                        res.tx_valid = 1'b1;
                        res.tx_byte  = it.wr_data;
                     end
                  end
                  ADDR_STATUS_A: begin
                     m_status = (it.wr_data & SA_WRITABLE) | (m_status & ~SA_WRITABLE);
                     // writing a one to TXC clears it
                     if (m_status[SA_TXC]) begin
                        m_status[SA_TXC] = 1'b0;
                        m_irq_txc = 1'b0;
                     end
                  end
                  ADDR_CONTROL_B: begin
                     m_ctrl_b = (it.wr_data & CB_WRITABLE) | (m_ctrl_b & ~CB_WRITABLE);
                     if (!m_ctrl_b[CB_RXEN])
                        m_full = 1'b0;
                     m_irq_rxc = m_ctrl_b[CB_RXCIE] & m_status[SA_RXC];
                     m_irq_txc = m_ctrl_b[CB_TXCIE] & m_status[SA_TXC];
                     m_irq_dre = m_ctrl_b[CB_DREIE] & m_status[SA_DRE];
                     m_mask = char_width_mask(m_ctrl_b, m_ctrl_c, m_mask);
                  end
                  ADDR_CONTROL_C: begin
                     m_ctrl_c = it.wr_data;
                     m_mask = char_width_mask(m_ctrl_b, m_ctrl_c, m_mask);
                  end
                  ADDR_BAUD_LOW:  m_baud_lo = it.wr_data;
                  ADDR_BAUD_HIGH: m_baud_hi = it.wr_data[3:0] & BAUD_HIGH_MASK;
                  default: ;
               endcase
            end
         end
         KIND_LINE: begin
            // drop the byte if the receiver is off or still holds one
            if (m_full || !m_ctrl_b[CB_RXEN]) begin
               res.rx_dropped = 1'b1;
            end else begin
               m_holder = it.rx_byte;
               m_full   = 1'b1;
               m_status[SA_RXC] = 1'b1;
               if (m_ctrl_b[CB_RXCIE])
                  m_irq_rxc = 1'b1;
            end
         end
         default: begin
            m_on = !it.level;
            if (it.level)
               clear_regs();
         end
      endcase
      res.rxc_irq  = m_irq_rxc;
      res.txc_irq  = m_irq_txc;
      res.dre_irq  = m_irq_dre;
      res.rx_ready = m_ctrl_b[CB_RXEN] & !m_full;
   endtask

   task automatic check_field(input string name, input logic [7:0] want_v,
                              input logic [7:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t ns: %s mismatch, expected %02h, actual %02h",
                  $time, name, want_v, got_v);
         fail_count++;
      end
   endtask

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch
      req_type item;
      rsp_type want;
      rsp_type got;
      if (reset) begin
         m_holder = '0;
         m_mask   = MASK_8;
         m_on     = 1'b1;
         clear_regs();
         predicted_replies.delete();
         fail_count = 0;
         pending    = 0;
         checked    = 0;
         tx_sent    = 0;
         dropped    = 0;
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            item.kind    = req_mon.kind;
            item.addr    = req_mon.addr;
            item.wr_data = req_mon.wr_data;
            item.rx_byte = req_mon.rx_byte;
            item.level   = req_mon.level;
            step_usart_regs(item, want);
            predicted_replies.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.read_data  = rsp_mon.read_data;
            got.tx_valid   = rsp_mon.tx_valid;
            got.tx_byte    = rsp_mon.tx_byte;
            got.rxc_irq    = rsp_mon.rxc_irq;
            got.txc_irq    = rsp_mon.txc_irq;
            got.dre_irq    = rsp_mon.dre_irq;
            got.rx_ready   = rsp_mon.rx_ready;
            got.rx_dropped = rsp_mon.rx_dropped;
            if (predicted_replies.size() == 0) begin
               $display("%0t ns: response with none expected, expected none, actual %h",
                        $time, got);
               fail_count++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
               check_field("tx_byte", want.tx_byte, got.tx_byte);
               check_field("rxc_irq", 8'(want.rxc_irq), 8'(got.rxc_irq));
               check_field("txc_irq", 8'(want.txc_irq), 8'(got.txc_irq));
               check_field("dre_irq", 8'(want.dre_irq), 8'(got.dre_irq));
               check_field("rx_ready", 8'(want.rx_ready), 8'(got.rx_ready));
               check_field("rx_dropped", 8'(want.rx_dropped), 8'(got.rx_dropped));
               checked++;
               if (want.tx_valid)
                  tx_sent++;
               if (want.rx_dropped)
                  dropped++;
            end
         end
         pending = predicted_replies.size();
      end
   end

endmodule

// File: test/usart_register_model_unit_tb.sv
// Testbench top for the USART register model: clock, reset, request stimulus with
// random gaps, response back-pressure, and the verdict.
// Depends on usrm_pkg, usrm_if, the block and usart_register_model_unit_checker.
`timescale 1ns / 100ps

module usart_register_model_unit_tb;
   import usrm_pkg::*;

   localparam addr_type ADDR_UNUSED = 3'd3;
   localparam byte_type RX_TX_ON    = (8'd1 << CB_RXEN) | (8'd1 << CB_TXEN);
   localparam byte_type ALL_IRQ_ON  = (8'd1 << CB_RXCIE) | (8'd1 << CB_TXCIE) |
                                      (8'd1 << CB_DREIE) | RX_TX_ON;
   localparam int       RANDOM_ITEMS = 1250;

   logic clock;
   logic reset;
   logic gaps_on;
   int   fail_count;
   int   pending;
   int   checked;
   int   tx_sent;
   int   dropped;
   int   directed_n;
   int   random_n;
   int   steady_n;

   usrm_req_if req_if();
   usrm_rsp_if rsp_if();

   usart_register_model_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   usart_register_model_unit_checker reply_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_if),
      .rsp_mon    (rsp_if),
      .fail_count (fail_count),
      .pending    (pending),
      .checked    (checked),
      .tx_sent    (tx_sent),
      .dropped    (dropped)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Back-pressure on the response side
   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !gaps_on || ($urandom_range(99) >= 25);
      end
   end

   // Hard stop in case the block hangs
   initial begin
      #400_000;
      $display("FAILURE");
      $finish;
   end

   function automatic req_type mk(kind_type k, addr_type a, byte_type wd, byte_type rx,
                                  logic lvl);
      req_type it;
      it.kind    = k;
      it.addr    = a;
      it.wr_data = wd;
      it.rx_byte = rx;
      it.level   = lvl;
      return it;
   endfunction

   // Present one item, idling first at random, and hold it until the transfer
   task automatic send_req(input req_type it);
      while (gaps_on && $urandom_range(99) < 25) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.kind    <= it.kind;
      req_if.addr    <= it.addr;
      req_if.wr_data <= it.wr_data;
      req_if.rx_byte <= it.rx_byte;
      req_if.level   <= it.level;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every predicted response has come back
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      @(posedge clock);
   endtask

   // Mostly bus traffic with the receiver and transmitter on; rare power cycles
   function automatic req_type pick_item();
      req_type it;
      int      r;
      it = mk(KIND_READ, addr_type'($urandom_range(6)), byte_type'($urandom),
              byte_type'($urandom), logic'($urandom_range(1)));
      r = $urandom_range(99);
      if (r < 30) begin
         if ($urandom_range(1))
            it.addr = ADDR_DATA;
      end else if (r < 66) begin
         it.kind = KIND_WRITE;
         case ($urandom_range(4))
            0, 1: it.addr = ADDR_DATA;
            2: begin
               it.addr = ADDR_CONTROL_B;
               if ($urandom_range(3) != 0)
                  it.wr_data = it.wr_data | RX_TX_ON;
            end
            default: ;
         endcase
      end else if (r < 96) begin
         it.kind = KIND_LINE;
      end else begin
         it.kind  = KIND_POWER;
         it.level = ($urandom_range(3) == 0);
      end
      return it;
   endfunction

   // Send random traffic until count items that the block acts on have gone in
   task automatic send_random(input int count, input logic with_gaps);
      req_type it;
      int      n;
      gaps_on = with_gaps;
      n = 0;
      while (n < count) begin
         if ($urandom_range(4) == 0) begin
            // receive sequence: a byte arrives, software picks it up
            send_req(mk(KIND_LINE, addr_type'($urandom_range(6)), byte_type'($urandom),
                        byte_type'($urandom), logic'($urandom_range(1))));
            send_req(mk(KIND_READ, ADDR_DATA, byte_type'($urandom), byte_type'($urandom),
                        logic'($urandom_range(1))));
            n += 2;
         end else begin
            it = pick_item();
            send_req(it);
            if (!((it.kind == KIND_READ || it.kind == KIND_WRITE) && it.addr == ADDR_UNUSED))
               n++;
         end
      end
      random_n += n;
      if (!with_gaps)
         steady_n += n;
   endtask

   initial begin : stimulus
      req_type plan[$];
      reset          = 1'b1;
      gaps_on        = 1'b1;
      req_if.valid   = 1'b0;
      req_if.kind    = KIND_READ;
      req_if.addr    = '0;
      req_if.wr_data = '0;
      req_if.rx_byte = '0;
      req_if.level   = 1'b0;
      directed_n     = 0;
      random_n       = 0;
      steady_n       = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Power-on values, unused offset, data read with the receiver off
      plan.push_back(mk(KIND_READ, ADDR_STATUS_A, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_CONTROL_C, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_UNUSED, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_DATA, 8'h00, 8'h00, 1'b0));
      // Baud extremes; the high register keeps four bits
      plan.push_back(mk(KIND_WRITE, ADDR_BAUD_LOW, 8'hFF, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_BAUD_HIGH, 8'hFF, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_BAUD_HIGH, 8'h00, 8'h00, 1'b0));
      // Five-bit characters, everything enabled, read-only bit written
      plan.push_back(mk(KIND_WRITE, ADDR_CONTROL_C, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_CONTROL_B, ALL_IRQ_ON | 8'h02, 8'h00, 1'b0));
      // Receive, overrun drop, masked read, read of an empty holder
      plan.push_back(mk(KIND_LINE, ADDR_DATA, 8'h00, 8'hFF, 1'b0));
      plan.push_back(mk(KIND_LINE, ADDR_DATA, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_DATA, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_DATA, 8'h00, 8'h00, 1'b0));
      // Transmit with interrupts on, then clear TXC by writing ones
      plan.push_back(mk(KIND_WRITE, ADDR_DATA, 8'hA5, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_STATUS_A, 8'hFF, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_STATUS_A, 8'h00, 8'h00, 1'b0));
      // Reserved size keeps the mask; receiver off drops; TXC stays without TXCIE
      plan.push_back(mk(KIND_WRITE, ADDR_CONTROL_B, (8'd1 << CB_CSZ2) | (8'd1 << CB_TXEN),
                        8'h00, 1'b0));
      plan.push_back(mk(KIND_LINE, ADDR_DATA, 8'h00, 8'h3C, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_DATA, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_CONTROL_C, CC_RESET, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_UNUSED, 8'hFF, 8'h00, 1'b0));
      // Power reduction: disabled block ignores the bus, then comes back reset
      plan.push_back(mk(KIND_POWER, ADDR_STATUS_A, 8'h00, 8'h00, 1'b1));
      plan.push_back(mk(KIND_READ, ADDR_STATUS_A, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_WRITE, ADDR_CONTROL_B, RX_TX_ON, 8'h00, 1'b0));
      plan.push_back(mk(KIND_POWER, ADDR_STATUS_A, 8'h00, 8'h00, 1'b0));
      plan.push_back(mk(KIND_READ, ADDR_CONTROL_B, 8'h00, 8'h00, 1'b0));
      foreach (plan[i])
         send_req(plan[i]);
      directed_n = plan.size();
      drain();

      // Random traffic: gaps, then a drained pause, a steady stretch, gaps again
      send_random(RANDOM_ITEMS / 2, 1'b1);
      drain();
      send_random(RANDOM_ITEMS / 4, 1'b0);
      send_random(RANDOM_ITEMS / 4, 1'b1);
      drain();
      repeat (8) @(posedge clock);

      $display("Ran %0d directed and %0d random items (%0d back to back), %0d responses checked.",
               directed_n, random_n, steady_n, checked);
      $display("Saw %0d bytes sent to the line and %0d arriving bytes dropped.",
               tx_sent, dropped);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
